FILE: rtl/ssc_pkg.sv
// Shared constants and types for the subset-sum counter.
// No dependencies; every other file imports this package.
package ssc_pkg;

    localparam int MAX_SUM_DEF = 1023;
    localparam int TGT_W       = 10;
    localparam int VAL_W       = 16;
    localparam int CNT_W       = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // One finished result handed from the engine to the output register
    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] count;
        logic             sat;
    } t_result;

endpackage

FILE: rtl/ssc_in_if.sv
// Input channel of the subset-sum counter: one set element per transfer.
// Depends on ssc_pkg for field widths.
interface ssc_in_if;
    import ssc_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] element_value;
    logic             is_last;

    modport source (output valid, output element_value, output is_last, input ready);
    modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

FILE: rtl/ssc_out_if.sv
// Output channel of the subset-sum counter: one count per finished set.
// Depends on ssc_pkg for field widths.
interface ssc_out_if;
    import ssc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] subset_count;
    logic             count_saturated;

    modport source (output valid, output subset_count, output count_saturated, input ready);
    modport sink   (input valid, input subset_count, input count_saturated, output ready);
endinterface

FILE: rtl/subset_sum_counter_top.sv
// Top level of the subset-sum counter: target register, output register, engine.
// Depends on ssc_pkg, ssc_in_if, ssc_out_if and ssc_engine.
//
// Counts the subsets of a streamed set of positive integers whose sum equals the
// target in the target register. The counts live in a single table of MAX_SUM+1
// 32-bit words held in a synchronous RAM with two read ports and one write port.
// One element is taken at a time: an element v with 0 < v <= target is taken in one
// transfer, then gets one read-modify-write per table entry from target down to v
// and a drain state for the last write-back; any other element only takes the
// transfer. An element marked last then reads the count at the target, waits until
// the output register is free, then runs a clearing sweep over entries 0..H, where
// H is the highest entry written in that set. After reset the same sweep covers the
// whole table, so no input transfer is taken until it ends; target writes are
// accepted at any time. A target above MAX_SUM acts as MAX_SUM. Counts saturate at
// 2^32-1 and count_saturated reports that it happened during the set. The output
// register lets a finished count wait for the sink while the next set streams in.
module subset_sum_counter_top #(
    parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ssc_pkg::TGT_W-1:0] i_cfg_wdata,
    ssc_in_if.sink                    i_in,
    ssc_out_if.source                 o_out
);
    import ssc_pkg::*;

    localparam int AW = (MAX_SUM < 1) ? 1 : $clog2(MAX_SUM + 1);

    logic [TGT_W-1:0] r_target;
    logic [AW-1:0]    eff_tgt;
    logic             out_free;
    t_result          res;

    logic             r_out_vld;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_sat;

    // Target register: hold until rewritten, never touches the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    // Clamp the target to the last table entry
    assign eff_tgt = (32'(r_target) > 32'(MAX_SUM)) ? AW'(MAX_SUM) : AW'(r_target);

    // Output register is free when empty or being drained this cycle
    assign out_free = !r_out_vld || o_out.ready;

    ssc_engine #(.MAX_SUM(MAX_SUM), .AW(AW)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tgt      (eff_tgt),
        .i_in_vld   (i_in.valid),
        .o_in_rdy   (i_in.ready),
        .i_value    (i_in.element_value),
        .i_last     (i_in.is_last),
        .i_out_free (out_free),
        .o_res      (res)
    );

    // Load a new count when free; drop the valid once the sink takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res.vld) begin
            r_out_cnt <= res.count;
            r_out_sat <= res.sat;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.subset_count    = r_out_cnt;
    assign o_out.count_saturated = r_out_sat;
endmodule

FILE: rtl/ssc_mem.sv
// Count table: two synchronous read ports, one write port, registered read data.
// Depends on ssc_pkg.
module ssc_mem #(
    parameter int DEPTH = ssc_pkg::MAX_SUM_DEF + 1,
    parameter int AW    = $clog2(ssc_pkg::MAX_SUM_DEF + 1)
) (
    input  logic                    i_clk,
    input  logic [AW-1:0]           i_rd_a_addr,
    input  logic [AW-1:0]           i_rd_b_addr,
    output logic [ssc_pkg::CNT_W-1:0] o_rd_a_data,
    output logic [ssc_pkg::CNT_W-1:0] o_rd_b_data,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [ssc_pkg::CNT_W-1:0] i_wr_data
);
    import ssc_pkg::*;

    logic [CNT_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_a_data <= mem[i_rd_a_addr];
        o_rd_b_data <= mem[i_rd_b_addr];
    end
endmodule

FILE: rtl/ssc_engine.sv
// Sequencer of the subset-sum counter: per-element read-modify-write sweep,
// result read-out and table clearing sweep. Depends on ssc_pkg and ssc_mem.
module ssc_engine #(
    parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF,
    parameter int AW      = $clog2(ssc_pkg::MAX_SUM_DEF + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [AW-1:0]             i_tgt,
    input  logic                      i_in_vld,
    output logic                      o_in_rdy,
    input  logic [ssc_pkg::VAL_W-1:0] i_value,
    input  logic                      i_last,
    input  logic                      i_out_free,
    output ssc_pkg::t_result          o_res
);
    import ssc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RUN     = 6'b000010,
        S_DRAIN   = 6'b000100,
        S_RES_RD  = 6'b001000,
        S_RES_OUT = 6'b010000,
        S_CLEAR   = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_t, n_t;
    logic [AW-1:0]  r_v, n_v;
    logic [AW-1:0]  r_tgt, n_tgt;
    logic           r_last, n_last;
    logic [AW-1:0]  r_hi, n_hi;
    logic [AW-1:0]  r_clr, n_clr;
    logic           r_ovf, n_ovf;
    logic           r_rd_vld;
    logic [AW-1:0]  r_wr_addr;

    logic [AW-1:0]    rd_a_addr, rd_b_addr, wr_addr;
    logic [CNT_W-1:0] rd_a_data, rd_b_data, wr_data;
    logic             we;
    logic [CNT_W:0]   sum;
    logic             accept, absorb;

    ssc_mem #(.DEPTH(MAX_SUM + 1), .AW(AW)) u_mem (
        .i_clk       (i_clk),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .o_rd_a_data (rd_a_data),
        .o_rd_b_data (rd_b_data),
        .i_we        (we),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data)
    );

    assign o_in_rdy = (r_state == S_IDLE);
    assign accept   = i_in_vld && o_in_rdy;
    assign absorb   = (i_value != '0) && (32'(i_value) <= 32'(i_tgt));

    // Read t and t-v; hold the result address otherwise so read data stays put
    assign rd_a_addr = (r_state == S_RUN) ? r_t : r_tgt;
    assign rd_b_addr = r_t - r_v;

    assign sum = {1'b0, rd_a_data} + {1'b0, rd_b_data};

    always_comb begin
        we      = r_rd_vld;
        wr_addr = r_wr_addr;
        wr_data = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
        if (r_state == S_CLEAR) begin
            we      = 1'b1;
            wr_addr = r_clr;
            wr_data = (r_clr == '0) ? CNT_W'(1) : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        n_v     = r_v;
        n_tgt   = r_tgt;
        n_last  = r_last;
        n_hi    = r_hi;
        n_clr   = r_clr;
        n_ovf   = r_ovf;
        o_res   = '{vld: 1'b0, count: rd_a_data, sat: r_ovf};

        if (r_rd_vld && sum[CNT_W]) begin
            n_ovf = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tgt  = i_tgt;
                    n_last = i_last;
                    if (absorb) begin
                        n_t     = i_tgt;
                        n_v     = AW'(i_value);
                        n_hi    = (i_tgt > r_hi) ? i_tgt : r_hi;
                        n_state = S_RUN;
                    end else if (i_last) begin
                        n_state = S_RES_RD;
                    end
                end
            end
            S_RUN: begin
                if (r_t == r_v) begin
                    n_state = S_DRAIN;
                end else begin
                    n_t = r_t - AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = r_last ? S_RES_RD : S_IDLE;
            end
            S_RES_RD: begin
                n_state = S_RES_OUT;
            end
            S_RES_OUT: begin
                if (i_out_free) begin
                    o_res.vld = 1'b1;
                    n_clr     = '0;
                    n_state   = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_clr == r_hi) begin
                    n_hi    = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_hi     <= AW'(MAX_SUM);
            r_ovf    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_hi     <= n_hi;
            r_ovf    <= n_ovf;
            r_rd_vld <= (r_state == S_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_t       <= n_t;
        r_v       <= n_v;
        r_tgt     <= n_tgt;
        r_last    <= n_last;
        r_wr_addr <= r_t;
    end

`ifndef NO_ASSERTIONS
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_t >= r_v) && (r_v != '0))
        else $error("sweep index fell below element value");

    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_t <= r_hi))
        else $error("write above tracked high-water mark");

    a_run_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |=> (r_state == S_RUN) || (r_state == S_DRAIN))
        else $error("sweep left without drain");

    a_no_write_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES_RD) || (r_state == S_RES_OUT) |-> !we)
        else $error("table written while result read is pending");

    a_res_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.vld |-> i_out_free)
        else $error("result issued into a full output register");
`endif
endmodule
